### hw/rtl/ttyld_pkg.sv
// ----------------------------------------------------------------------------
// ttyld_pkg
// Shared types, character codes and command/status structs for the terminal
// input line discipline.
// ----------------------------------------------------------------------------
package ttyld_pkg;

  localparam int TTYLD_LINE_DEPTH = 64;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_INPUT_MODES  = 2'd0;
  localparam logic [1:0] REG_LOCAL_MODES  = 2'd1;
  localparam logic [1:0] REG_SIGNAL_CHARS = 2'd2;
  localparam logic [1:0] REG_EDIT_CHARS   = 2'd3;

  localparam logic [3:0]  INPUT_MODES_RST  = 4'h4;
  localparam logic [5:0]  LOCAL_MODES_RST  = 6'h3F;
  localparam logic [23:0] SIGNAL_CHARS_RST = 24'h1A1C03;
  localparam logic [31:0] EDIT_CHARS_RST   = 32'h0400157F;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CTRL_FLIP  = 8'h40;

  // Signal codes
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INT  = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;
  localparam logic [1:0] SIG_SUSP = 2'd3;

  // Item classes decoded by the datapath
  localparam logic [2:0] CLS_IGNORE = 3'd0;
  localparam logic [2:0] CLS_SIGNAL = 3'd1;
  localparam logic [2:0] CLS_PLAIN  = 3'd2;
  localparam logic [2:0] CLS_ERASE  = 3'd3;
  localparam logic [2:0] CLS_KILL   = 3'd4;
  localparam logic [2:0] CLS_READ   = 3'd5;

  // Result kinds loaded into the output register
  localparam logic [1:0] OK_ZERO = 2'd0;
  localparam logic [1:0] OK_SIG  = 2'd1;
  localparam logic [1:0] OK_RECV = 2'd2;
  localparam logic [1:0] OK_RUN  = 2'd3;

  typedef struct packed {
    logic       in_ready;
    logic       latch;
    logic       start_run;
    logic       mem_rd;
    logic       inc_k;
    logic       clr_k;
    logic       set_n;
    logic       n_plus1;
    logic       load;
    logic [1:0] okind;
    logic       append;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] cls;
    logic       out_free;
    logic       k_eq_limit;
    logic       n_zero;
    logic       k_last;
    logic       stop_before;
    logic       stop_after;
  } st_t;

endpackage

### hw/rtl/ttyld_if.sv
// ----------------------------------------------------------------------------
// ttyld channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ttyld_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;
  logic [6:0] read_count;

  modport source (output valid, operation, in_byte, read_count, input ready);
  modport sink (input valid, operation, in_byte, read_count, output ready);
endinterface

interface ttyld_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] echo_bytes;
  logic [2:0]  echo_len;
  logic [1:0]  signal_code;
  logic        wake_reader;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic        readable;
  logic        last;

  modport source (output valid, echo_bytes, echo_len, signal_code, wake_reader,
                  read_byte, read_valid, readable, last, input ready);
  modport sink (input valid, echo_bytes, echo_len, signal_code, wake_reader,
                read_byte, read_valid, readable, last, output ready);
endinterface

interface ttyld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/tty_line_discipline_input.sv
// ----------------------------------------------------------------------------
// tty_line_discipline_input
// Terminal input line discipline: receive translation, signals, canonical
// editing and a circular line store drained by read requests.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one item per beat (operation 0 receives in_byte,
// operation 1 asks for up to read_count bytes). out_ch returns the results
// of that item, one per beat, the final one flagged by last. cfg_ch writes
// the four mode/character registers and is always ready; write only while
// no item is in flight.
// Throughput: one item at a time. A plain receive, signal or ignored CR
// loads its result from the decode state once the result register is
// free, and the controller then returns to idle for the next item. Erase,
// kill and read walk the line store through its single registered read
// port: a scan pass that reads and checks each inspected byte, then an
// emit pass that reads each byte again and loads one result for it.
// Reset: the configuration registers return to their defaults and the store
// is empty (level and front pointer cleared); no clearing pass is needed.
// Back-pressure: the result register holds while out_ch.ready is low and
// the controller waits; the next item is taken as soon as the controller
// is idle, even with the last result still pending.
// ----------------------------------------------------------------------------
module tty_line_discipline_input
  import ttyld_pkg::*;
#(
  parameter int LINE_DEPTH = TTYLD_LINE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  ttyld_in_if.sink     in_ch,
  ttyld_out_if.source  out_ch,
  ttyld_cfg_if.sink    cfg_ch
);

  cmd_t cmd;
  st_t  st;

  ttyld_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  ttyld_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

### hw/rtl/ttyld_dp.sv
// ----------------------------------------------------------------------------
// ttyld_dp
// Datapath: configuration registers, byte translation and classification,
// line store with its level and front pointer, run counters, result register.
// ----------------------------------------------------------------------------
module ttyld_dp
  import ttyld_pkg::*;
#(
  parameter int LINE_DEPTH = TTYLD_LINE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  ttyld_in_if.sink          in_ch,
  ttyld_out_if.source       out_ch,
  ttyld_cfg_if.sink         cfg_ch,
  input  cmd_t              cmd,
  output st_t               st
);

  localparam int PTR_W  = $clog2(LINE_DEPTH);
  localparam int FILL_W = $clog2(LINE_DEPTH + 1);
  localparam logic [PTR_W:0]    DEPTH_W = (PTR_W + 1)'(LINE_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(LINE_DEPTH);

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < CTRL_LIMIT) || (b == CH_DEL);
  endfunction

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] p);
    return (p >= DEPTH_W) ? PTR_W'(p - DEPTH_W) : p[PTR_W-1:0];
  endfunction

  // Configuration
  logic [3:0]  im_r;
  logic [5:0]  lm_r;
  logic [23:0] sc_r;
  logic [31:0] ec_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      im_r <= INPUT_MODES_RST;
      lm_r <= LOCAL_MODES_RST;
      sc_r <= SIGNAL_CHARS_RST;
      ec_r <= EDIT_CHARS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_INPUT_MODES:  im_r <= cfg_ch.data[3:0];
        REG_LOCAL_MODES:  lm_r <= cfg_ch.data[5:0];
        REG_SIGNAL_CHARS: sc_r <= cfg_ch.data[23:0];
        REG_EDIT_CHARS:   ec_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Item registers
  logic       op_r;
  logic [7:0] raw_r;
  logic [6:0] count_r;

  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_ch.operation;
      raw_r   <= in_ch.in_byte;
      count_r <= in_ch.read_count;
    end
  end

  // Translation and classification of a received byte
  logic       canon;
  logic [7:0] c1, c2, cx;
  logic       ign_cr, erase_hit, kill_hit, le_hit, eof_hit;
  logic       append, nl_echo, wake, echo_on;
  logic [1:0] sig_code;
  logic [2:0] cls;
  logic [15:0] rx_echo;
  logic [2:0]  rx_len;

  assign canon = lm_r[4];

  always_comb begin
    c1 = im_r[0] ? {1'b0, raw_r[6:0]} : raw_r;
    ign_cr = (c1 == CH_CR) && im_r[1];
    c2 = ((c1 == CH_CR) && im_r[2]) ? CH_NL : c1;
    cx = (im_r[3] && (c2 == CH_NL)) ? CH_CR : c2;

    sig_code = SIG_NONE;
    if (lm_r[5]) begin
      if (cx == sc_r[7:0])        sig_code = SIG_INT;
      else if (cx == sc_r[15:8])  sig_code = SIG_QUIT;
      else if (cx == sc_r[23:16]) sig_code = SIG_SUSP;
    end

    erase_hit = canon && lm_r[1] &&
                ((cx == CH_BS) || (cx == CH_DEL) || (cx == ec_r[7:0]));
    kill_hit  = canon && lm_r[2] && (cx == ec_r[15:8]);
    eof_hit   = canon && (cx == ec_r[31:24]);
    le_hit    = canon && ((cx == CH_NL) || (cx == ec_r[23:16]) || eof_hit);
    append     = !eof_hit;
    nl_echo    = le_hit && !eof_hit && lm_r[3];
    wake       = !canon || le_hit;
    echo_on    = append && (nl_echo || lm_r[0]);

    rx_echo = 16'h0000;
    rx_len  = 3'd0;
    if (echo_on) begin
      if (((cx < CTRL_LIMIT) && (cx != CH_NL) && (cx != CH_TAB)) || (cx == CH_DEL)) begin
        rx_echo = {((cx == CH_DEL) ? CH_QMARK : (cx ^ CTRL_FLIP)), CH_CARET};
        rx_len  = 3'd2;
      end else if (canon && (cx == CH_NL)) begin
        rx_echo = {CH_NL, CH_CR};
        rx_len  = 3'd2;
      end else begin
        rx_echo = {8'h00, cx};
        rx_len  = 3'd1;
      end
    end

    if (op_r)                  cls = CLS_READ;
    else if (ign_cr)           cls = CLS_IGNORE;
    else if (sig_code != SIG_NONE) cls = CLS_SIGNAL;
    else if (erase_hit)        cls = CLS_ERASE;
    else if (kill_hit)         cls = CLS_KILL;
    else                       cls = CLS_PLAIN;
  end

  // Line store state and run counters
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [FILL_W-1:0] k_r, n_r, limit_r;
  logic              back_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [LINE_DEPTH];

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr, rd_off;
  logic [FILL_W-1:0] cnt_f, run_limit;

  // EOF is never stored
  assign wr_en   = cmd.append && append && (fill_r < DEPTH_F);
  assign wr_addr = wrap((PTR_W + 1)'(front_r) + (PTR_W + 1)'(fill_r));
  assign rd_off  = back_r ? PTR_W'(fill_r - k_r - FILL_W'(1)) : PTR_W'(k_r);
  assign rd_addr = wrap((PTR_W + 1)'(front_r) + (PTR_W + 1)'(rd_off));

  always_comb begin
    cnt_f = (count_r < 7'(fill_r)) ? FILL_W'(count_r) : fill_r;
    case (cls)
      CLS_READ:  run_limit = cnt_f;
      CLS_ERASE: run_limit = (fill_r != '0) ? FILL_W'(1) : '0;
      default:   run_limit = fill_r;
    endcase
  end

  always_comb begin
    fill_nxt  = fill_r;
    front_nxt = front_r;
    if (wr_en) fill_nxt = fill_r + FILL_W'(1);
    if (cmd.commit) begin
      fill_nxt = fill_r - n_r;
      if (!back_r) front_nxt = wrap((PTR_W + 1)'(front_r) + (PTR_W + 1)'(n_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      front_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      front_r <= front_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cx;
    if (cmd.mem_rd) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      n_r     <= '0;
      limit_r <= '0;
      back_r  <= 1'b0;
    end else begin
      if (cmd.start_run) begin
        limit_r <= run_limit;
        back_r  <= (cls != CLS_READ);
      end
      if (cmd.start_run || cmd.clr_k) k_r <= '0;
      else if (cmd.inc_k)             k_r <= k_r + FILL_W'(1);
      if (cmd.set_n) n_r <= cmd.n_plus1 ? k_r + FILL_W'(1) : k_r;
    end
  end

  // Result register
  logic        out_valid_r;
  logic [47:0] echo_bytes_r;
  logic [2:0]  echo_len_r;
  logic [1:0]  signal_code_r;
  logic        wake_r, read_valid_r, readable_r, last_r;
  logic [7:0]  read_byte_r;
  logic        k_last;

  assign k_last = (FILL_W'(k_r + FILL_W'(1)) == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      echo_bytes_r  <= '0;
      echo_len_r    <= 3'd0;
      signal_code_r <= SIG_NONE;
      wake_r        <= 1'b0;
      read_byte_r   <= 8'h00;
      read_valid_r  <= 1'b0;
      readable_r    <= (fill_r != '0);
      last_r        <= 1'b1;
      case (cmd.okind)
        OK_SIG: signal_code_r <= sig_code;
        OK_RECV: begin
          echo_bytes_r <= {32'h0, rx_echo};
          echo_len_r   <= rx_len;
          wake_r       <= wake;
          readable_r   <= (fill_r != '0) || append;
        end
        OK_RUN: begin
          readable_r <= (fill_r != n_r);
          last_r     <= k_last;
          if (back_r) begin
            if (is_ctrl(rd_data_r)) begin
              echo_bytes_r <= {CH_BS, CH_BS, CH_SPACE, CH_SPACE, CH_BS, CH_BS};
              echo_len_r   <= 3'd6;
            end else begin
              echo_bytes_r <= {24'h0, CH_BS, CH_SPACE, CH_BS};
              echo_len_r   <= 3'd3;
            end
          end else begin
            read_byte_r  <= rd_data_r;
            read_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.echo_bytes  = echo_bytes_r;
  assign out_ch.echo_len    = echo_len_r;
  assign out_ch.signal_code = signal_code_r;
  assign out_ch.wake_reader = wake_r;
  assign out_ch.read_byte   = read_byte_r;
  assign out_ch.read_valid  = read_valid_r;
  assign out_ch.readable    = readable_r;
  assign out_ch.last        = last_r;

  // Status to the controller
  logic rd_line_end;
  assign rd_line_end = canon && ((rd_data_r == CH_NL) || (rd_data_r == ec_r[23:16]) ||
                                 (rd_data_r == ec_r[31:24]));

  always_comb begin
    st.in_valid    = in_ch.valid;
    st.cls         = cls;
    st.out_free    = !out_valid_r || out_ch.ready;
    st.k_eq_limit  = (k_r == limit_r);
    st.n_zero      = (n_r == '0);
    st.k_last      = k_last;
    st.stop_before = back_r && (rd_data_r == CH_NL);
    st.stop_after  = !back_r && rd_line_end;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("line store level beyond depth");

  a_commit_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> fill_r == $past(fill_r - n_r))
    else $error("run commit left a wrong level");

endmodule

### hw/rtl/ttyld_ctrl.sv
// ----------------------------------------------------------------------------
// ttyld_ctrl
// Controller: takes an item, dispatches single results, and sequences the
// scan and emit passes of erase, kill and read runs over the line store.
// ----------------------------------------------------------------------------
module ttyld_ctrl
  import ttyld_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DECODE    = 3'd1;
  localparam logic [2:0] ST_SCAN_RD   = 3'd2;
  localparam logic [2:0] ST_SCAN_CHK  = 3'd3;
  localparam logic [2:0] ST_RUN_START = 3'd4;
  localparam logic [2:0] ST_EMIT_RD   = 3'd5;
  localparam logic [2:0] ST_EMIT_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((st.cls == CLS_ERASE) || (st.cls == CLS_KILL) || (st.cls == CLS_READ)) begin
          cmd.start_run = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end else if (st.out_free) begin
          cmd.load = 1'b1;
          case (st.cls)
            CLS_SIGNAL: cmd.okind = OK_SIG;
            CLS_PLAIN: begin
              cmd.okind  = OK_RECV;
              cmd.append = 1'b1;
            end
            default:    cmd.okind = OK_ZERO;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (st.k_eq_limit) begin
          cmd.set_n = 1'b1;
          state_nxt = ST_RUN_START;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        // stop short of a newline when erasing, just after a line end when reading
        if (st.stop_before) begin
          cmd.set_n = 1'b1;
          state_nxt = ST_RUN_START;
        end else if (st.stop_after) begin
          cmd.set_n   = 1'b1;
          cmd.n_plus1 = 1'b1;
          state_nxt   = ST_RUN_START;
        end else begin
          cmd.inc_k = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_RUN_START: begin
        if (!st.n_zero) begin
          cmd.clr_k = 1'b1;
          state_nxt = ST_EMIT_RD;
        end else if (st.out_free) begin
          cmd.load  = 1'b1;
          cmd.okind = OK_ZERO;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (st.out_free) begin
          cmd.load  = 1'b1;
          cmd.okind = OK_RUN;
          cmd.inc_k = 1'b1;
          if (st.k_last) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st.out_free)
    else $error("result loaded over an untaken beat");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (cmd.load && st.k_last && (state_r == ST_EMIT_OUT)))
    else $error("run committed before its last result");

endmodule

### sim/ttyld_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttyld_tb_pkg
// Item operation codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package ttyld_tb_pkg;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

endpackage

### sim/ttyld_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttyld_checker
// Watches the item, result and configuration channels of the line discipline,
// works out every result beat from its own copy of the mode registers and the
// line store, and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module ttyld_checker
  import ttyld_pkg::*;
  import ttyld_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ttyld_in_if  in_ch,
  ttyld_out_if out_ch,
  ttyld_cfg_if cfg_ch,
  output int   mismatches,
  output int   pending,
  output int   beats_checked
);

  localparam int unsigned DEPTH     = TTYLD_LINE_DEPTH;
  localparam int          MAX_SHOWN = 100;
  localparam logic [47:0] RUB_CTRL  = {CH_BS, CH_BS, CH_SPACE, CH_SPACE, CH_BS, CH_BS};
  localparam logic [47:0] RUB_PLAIN = {24'h0, CH_BS, CH_SPACE, CH_BS};

  typedef struct packed {
    logic [47:0] echo;
    logic [2:0]  echo_len;
    logic [1:0]  sig;
    logic        wake;
    logic [7:0]  rbyte;
    logic        rvalid;
    logic        readable;
    logic        last;
  } tty_result_t;

  logic [3:0]  in_modes;
  logic [5:0]  lc_modes;
  logic [23:0] sig_chars;
  logic [31:0] ed_chars;

  logic [7:0]  line_buf [DEPTH];
  int unsigned fill;
  int unsigned head;

  tty_result_t step_results[$];
  tty_result_t results_due[$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    beats_checked = 0;
  end

  function automatic int unsigned wrap_idx(int unsigned p);
    return (p >= DEPTH) ? p - DEPTH : p;
  endfunction

  function automatic logic [7:0] newest_char();
    return line_buf[wrap_idx(head + fill - 1)];
  endfunction

  function automatic logic is_ctrl(logic [7:0] c);
    return (c < CTRL_LIMIT) || (c == CH_DEL);
  endfunction

  function automatic void add_result(logic [47:0] echo, logic [2:0] elen, logic [1:0] sig,
                                     logic wake, logic [7:0] rbyte, logic rvalid);
    tty_result_t r;
    r          = '0;
    r.echo     = echo;
    r.echo_len = elen;
    r.sig      = sig;
    r.wake     = wake;
    r.rbyte    = rbyte;
    r.rvalid   = rvalid;
    step_results.push_back(r);
  endfunction

  // Drop the newest stored byte and give its backspace group.
  function automatic void rub_out();
    if (is_ctrl(newest_char()))
      add_result(RUB_CTRL, 3'd6, SIG_NONE, 1'b0, 8'h00, 1'b0);
    else
      add_result(RUB_PLAIN, 3'd3, SIG_NONE, 1'b0, 8'h00, 1'b0);
    fill--;
  endfunction

  function automatic void line_rx(logic [7:0] raw);
    logic [7:0]  c;
    logic [7:0]  erase_c;
    logic [7:0]  kill_c;
    logic [7:0]  eol_c;
    logic [7:0]  eof_c;
    logic        canon;
    logic        nl_echo;
    logic        wake;
    logic        keep;
    logic [1:0]  sig;
    logic [47:0] echo;
    logic [2:0]  elen;
    int          n;
    erase_c    = ed_chars[7:0];
    kill_c     = ed_chars[15:8];
    eol_c      = ed_chars[23:16];
    eof_c      = ed_chars[31:24];
    canon      = lc_modes[4];
    nl_echo    = 1'b0;
    wake       = 1'b0;
    keep       = 1'b1;
    sig        = SIG_NONE;
    echo       = '0;
    elen       = 3'd0;

    c = in_modes[0] ? {1'b0, raw[6:0]} : raw;
    if (c == CH_CR) begin
      if (in_modes[1]) begin
        add_result('0, 3'd0, SIG_NONE, 1'b0, 8'h00, 1'b0);
        return;
      end
      if (in_modes[2])
        c = CH_NL;
    end
    if (in_modes[3] && c == CH_NL)
      c = CH_CR;

    // Interrupt wins over quit, quit over suspend
    if (lc_modes[5]) begin
      if (c == sig_chars[7:0])
        sig = SIG_INT;
      else if (c == sig_chars[15:8])
        sig = SIG_QUIT;
      else if (c == sig_chars[23:16])
        sig = SIG_SUSP;
      if (sig != SIG_NONE) begin
        add_result('0, 3'd0, sig, 1'b0, 8'h00, 1'b0);
        return;
      end
    end

    if (canon) begin
      if ((c == CH_BS || c == CH_DEL || c == erase_c) && lc_modes[1]) begin
        if (fill > 0 && newest_char() != CH_NL)
          rub_out();
        else
          add_result('0, 3'd0, SIG_NONE, 1'b0, 8'h00, 1'b0);
        return;
      end
      if (c == kill_c && lc_modes[2]) begin
        n = 0;
        while (fill > 0 && newest_char() != CH_NL) begin
          rub_out();
          n++;
        end
        if (n == 0)
          add_result('0, 3'd0, SIG_NONE, 1'b0, 8'h00, 1'b0);
        return;
      end
      if (c == CH_NL || c == eol_c || c == eof_c) begin
        wake = 1'b1;
        if (c == eof_c)
          keep = 1'b0;
        else
          nl_echo = lc_modes[3];
      end
    end else begin
      wake = 1'b1;
    end

    if (keep) begin
      // A full store drops the byte but still echoes it
      if (fill < DEPTH) begin
        line_buf[wrap_idx(head + fill)] = c;
        fill++;
      end
      if (nl_echo || lc_modes[0]) begin
        if ((c < CTRL_LIMIT && c != CH_NL && c != CH_TAB) || c == CH_DEL) begin
          echo = {32'h0, (c == CH_DEL) ? CH_QMARK : (c ^ CTRL_FLIP), CH_CARET};
          elen = 3'd2;
        end else if (canon && c == CH_NL) begin
          echo = {32'h0, CH_NL, CH_CR};
          elen = 3'd2;
        end else begin
          echo = {40'h0, c};
          elen = 3'd1;
        end
      end
    end
    add_result(echo, elen, SIG_NONE, wake, 8'h00, 1'b0);
  endfunction

  function automatic void line_read(logic [6:0] cnt);
    int unsigned span;
    logic [7:0]  b;
    if (fill == 0 || cnt == 0) begin
      add_result('0, 3'd0, SIG_NONE, 1'b0, 8'h00, 1'b0);
      return;
    end
    span = (cnt < fill) ? cnt : fill;
    for (int unsigned k = 0; k < span; k++) begin
      b    = line_buf[head];
      head = wrap_idx(head + 1);
      fill--;
      add_result('0, 3'd0, SIG_NONE, 1'b0, b, 1'b1);
      // Canonical reads end after a line terminator
      if (lc_modes[4] && (b == CH_NL || b == ed_chars[23:16] || b == ed_chars[31:24]))
        break;
    end
  endfunction

  // Stamp readable and last on the beats of this item and queue them.
  function automatic void seal_step();
    foreach (step_results[i]) begin
      step_results[i].readable = (fill > 0);
      step_results[i].last     = (i == step_results.size() - 1);
      results_due.push_back(step_results[i]);
    end
    step_results.delete();
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t ERROR %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want)
      report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                       beats_checked, name, got, want));
  endtask

  always @(posedge clk) begin
    tty_result_t got;
    tty_result_t want;
    if (!rst_n) begin
      in_modes  = INPUT_MODES_RST;
      lc_modes  = LOCAL_MODES_RST;
      sig_chars = SIGNAL_CHARS_RST;
      ed_chars  = EDIT_CHARS_RST;
      fill      = 0;
      head      = 0;
      step_results.delete();
      results_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_INPUT_MODES:  in_modes  = cfg_ch.data[3:0];
          REG_LOCAL_MODES:  lc_modes  = cfg_ch.data[5:0];
          REG_SIGNAL_CHARS: sig_chars = cfg_ch.data[23:0];
          REG_EDIT_CHARS:   ed_chars  = cfg_ch.data;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.echo     = out_ch.echo_bytes;
        got.echo_len = out_ch.echo_len;
        got.sig      = out_ch.signal_code;
        got.wake     = out_ch.wake_reader;
        got.rbyte    = out_ch.read_byte;
        got.rvalid   = out_ch.read_valid;
        got.readable = out_ch.readable;
        got.last     = out_ch.last;
        if (results_due.size() == 0) begin
          report($sformatf("beat %0d arrived with nothing due (0x%0h)", beats_checked, got));
        end else begin
          want = results_due.pop_front();
          check_field("echo_bytes", got.echo, want.echo);
          check_field("echo_len", 48'(got.echo_len), 48'(want.echo_len));
          check_field("signal_code", 48'(got.sig), 48'(want.sig));
          check_field("wake_reader", 48'(got.wake), 48'(want.wake));
          check_field("read_byte", 48'(got.rbyte), 48'(want.rbyte));
          check_field("read_valid", 48'(got.rvalid), 48'(want.rvalid));
          check_field("readable", 48'(got.readable), 48'(want.readable));
          check_field("last", 48'(got.last), 48'(want.last));
        end
        beats_checked++;
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_READ)
          line_read(in_ch.read_count);
        else
          line_rx(in_ch.in_byte);
        seal_step();
      end
    end
    pending = results_due.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the line discipline with a directed opening and then random typed
// lines, edits, signals and reads under several register settings, with
// sender gaps and receiver stalls; a separate checker judges every result.
// ----------------------------------------------------------------------------
module tb;
  import ttyld_pkg::*;
  import ttyld_tb_pkg::*;

  localparam int READ_TAG   = 'h100;
  localparam int N_PHASES   = 7;
  localparam int PHASE_ITEMS = 22;

  logic clk;
  logic rst_n;

  ttyld_in_if  in_ch();
  ttyld_out_if out_ch();
  ttyld_cfg_if cfg_ch();

  int mismatches;
  int pending;
  int beats_checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_items        = 0;
  int n_reads        = 0;
  int n_settings     = 0;

  logic [3:0]  cur_in;
  logic [5:0]  cur_lm;
  logic [23:0] cur_sig;
  logic [31:0] cur_edit;

  tty_line_discipline_input u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ttyld_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d result beats still due", pending);
    $display("Mismatches found");
    $finish;
  end

  // Valid is left high on return; the next call or settle decides its level.
  task automatic push_item(input logic op, input logic [7:0] b, input logic [6:0] cnt);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.in_byte    <= b;
    in_ch.read_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_items++;
    if (op == OP_READ)
      n_reads++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] im, input logic [5:0] lm,
                               input logic [23:0] sc, input logic [31:0] ec);
    cur_in   = im;
    cur_lm   = lm;
    cur_sig  = sc;
    cur_edit = ec;
    write_reg(REG_INPUT_MODES, {28'h0, im});
    write_reg(REG_LOCAL_MODES, {26'h0, lm});
    write_reg(REG_SIGNAL_CHARS, {8'h0, sc});
    write_reg(REG_EDIT_CHARS, ec);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Drop valid, drain every due result, then let the controller go idle.
  task automatic settle(input int tail);
    in_ch.valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return 8'($urandom_range(8'h7E, 8'h20));
    if (r < 70)
      return 8'($urandom_range(255));
    if (r < 78) begin
      case ($urandom_range(2))
        0:       return CH_BS;
        1:       return CH_DEL;
        default: return cur_edit[7:0];
      endcase
    end
    if (r < 83)
      return cur_edit[15:8];
    if (r < 88)
      return cur_sig[8 * $urandom_range(2) +: 8];
    return 8'($urandom_range(31));
  endfunction

  function automatic logic [6:0] read_size();
    int r;
    r = $urandom_range(99);
    if (r < 10)
      return 7'd0;
    if (r < 20)
      return 7'($urandom_range(127, 65));
    if (r < 30)
      return 7'd64;
    return 7'($urandom_range(20, 1));
  endfunction

  // Mostly typed lines with a terminator and reads; some floods and noise.
  task automatic random_phase(input int target);
    int start;
    int r;
    int len;
    logic [7:0] term;
    start = n_items;
    while (n_items - start < target) begin
      r = $urandom_range(99);
      if (r < 15) begin
        repeat ($urandom_range(6, 1))
          push_item(1'($urandom_range(1)), 8'($urandom_range(255)), 7'($urandom_range(127)));
      end else begin
        len = (r < 19) ? $urandom_range(72, 60) : $urandom_range(12, 1);
        repeat (len)
          push_item(OP_RECEIVE, (r < 19) ? 8'($urandom_range(8'h7E, 8'h20)) : pick_byte(),
                    7'($urandom_range(127)));
        case ($urandom_range(3))
          0:       term = CH_NL;
          1:       term = CH_CR;
          2:       term = cur_edit[23:16];
          default: term = cur_edit[31:24];
        endcase
        push_item(OP_RECEIVE, term, 7'($urandom_range(127)));
        repeat ($urandom_range(3))
          push_item(OP_READ, 8'($urandom_range(255)), read_size());
      end
    end
  endtask

  initial begin
    int script[] = '{READ_TAG + 5, CH_DEL, 'h15, 'h61, 'hFF, 'h01, CH_TAB, CH_BS, CH_DEL,
                     'h03, 'h1C, 'h1A, CH_CR, CH_DEL, 'h62, 'h80, 'h15, 'h00, 'h04,
                     READ_TAG + 127, READ_TAG + 0, READ_TAG + 1, CH_NL, READ_TAG + 64};
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_RECEIVE;
    in_ch.in_byte     = 8'h00;
    in_ch.read_count  = 7'd0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_INPUT_MODES;
    cfg_ch.data       = 32'h0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_setting(INPUT_MODES_RST, LOCAL_MODES_RST, SIGNAL_CHARS_RST, EDIT_CHARS_RST);

    // Directed opening under the reset settings
    foreach (script[i]) begin
      if (script[i] >= READ_TAG)
        push_item(OP_READ, 8'h00, 7'(script[i] - READ_TAG));
      else
        push_item(OP_RECEIVE, 8'(script[i]), 7'd0);
    end
    random_phase(PHASE_ITEMS);

    for (int ph = 1; ph < N_PHASES; ph++) begin
      settle(8);
      case (ph)
        1:       apply_setting(4'h0, 6'h0F, 24'h000000, 32'hFFFFFFFF);
        2:       apply_setting(4'hF, 6'h3F, 24'hFFFFFF, 32'h00000000);
        3:       apply_setting(4'h2, 6'h3E, 24'h030303, 32'h2E3B1508);
        4:       apply_setting(4'h8, 6'h00, SIGNAL_CHARS_RST, EDIT_CHARS_RST);
        default: apply_setting(4'($urandom), 6'($urandom), 24'($urandom), $urandom);
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    settle(20);
    $display("Sent %0d items (%0d reads) under %0d register settings", n_items, n_reads,
             n_settings);
    $display("Compared %0d result beats over free-running, gapped and stalled phases",
             beats_checked);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
